>>> design/sdple_pkg.sv
package sdple_pkg;

	localparam int unsigned MAX_ELEMENT_INDEX = 63;
	localparam int unsigned IDX_W = 6;
	localparam logic [IDX_W-1:0] CNT_LIMIT =
		(MAX_ELEMENT_INDEX > 63) ? IDX_W'(63) : IDX_W'(MAX_ELEMENT_INDEX);

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_EQ  = 8'd61;

	localparam logic [6:0] DELIM_RESET = 7'd32;

	typedef enum logic [6:0] {
		PH_HEADER   = 7'b0000001,
		PH_AFTER_EQ = 7'b0000010,
		PH_BODY     = 7'b0000100,
		PH_AFTER_CR = 7'b0001000,
		PH_AFTER_LF = 7'b0010000,
		PH_ACCEPTED = 7'b0100000,
		PH_ERROR    = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_HEADER  = 2'd0,
		ROLE_ELEMENT = 2'd1,
		ROLE_SEP     = 2'd2
	} role_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_ERROR    = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]       line_byte;
		logic             line_start;
	} item_t;

	typedef struct packed {
		logic [7:0]       byte_out;
		role_t            byte_role;
		logic             element_start;
		logic [IDX_W-1:0] element_index;
		status_t          line_status;
	} result_t;

endpackage

>>> design/sdple_parse.sv
module sdple_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_data,
	input  logic              advance,
	input  sdple_pkg::item_t  item,
	output sdple_pkg::result_t result
);

	logic [6:0]                     delim_q;
	sdple_pkg::phase_t              phase_q;
	logic                           in_elem_q;
	logic [sdple_pkg::IDX_W-1:0]    count_q;

	sdple_pkg::phase_t              ph;
	sdple_pkg::phase_t              nph;
	logic                           ie;
	logic                           nie;
	logic [sdple_pkg::IDX_W-1:0]    cnt;
	logic [sdple_pkg::IDX_W-1:0]    ncnt;
	logic                           body;
	logic [7:0]                     b;
	sdple_pkg::role_t               role;
	logic                           start;
	sdple_pkg::status_t             status;

	assign b = item.line_byte;

	always_comb begin
		ph    = item.line_start ? sdple_pkg::PH_HEADER : phase_q;
		ie    = item.line_start ? 1'b0 : in_elem_q;
		cnt   = item.line_start ? '0 : count_q;
		nph   = ph;
		nie   = ie;
		ncnt  = cnt;
		body  = 1'b0;
		role  = sdple_pkg::ROLE_SEP;
		start = 1'b0;

		unique case (ph)
			sdple_pkg::PH_HEADER: begin
				if (b == sdple_pkg::CH_NUL || b == sdple_pkg::CH_LF || b == sdple_pkg::CH_CR) begin
					nph = sdple_pkg::PH_ERROR;
				end else begin
					role = sdple_pkg::ROLE_HEADER;
					start = ~ie;
					nie = 1'b1;
					if (b == sdple_pkg::CH_EQ) begin
						nie = 1'b0;
						nph = sdple_pkg::PH_AFTER_EQ;
					end
				end
			end
			sdple_pkg::PH_AFTER_EQ: begin
				if (b == sdple_pkg::CH_SP) begin
					nph = sdple_pkg::PH_ERROR;
				end else begin
					body = 1'b1;
				end
			end
			sdple_pkg::PH_BODY: begin
				body = 1'b1;
			end
			sdple_pkg::PH_AFTER_CR: begin
				nie = 1'b0;
				if (b == sdple_pkg::CH_LF) begin
					nph = sdple_pkg::PH_AFTER_LF;
				end else if (b == sdple_pkg::CH_NUL) begin
					nph = sdple_pkg::PH_ERROR;
				end else begin
					nph = sdple_pkg::PH_BODY;
				end
			end
			sdple_pkg::PH_AFTER_LF: begin
				nph = (b == sdple_pkg::CH_NUL) ? sdple_pkg::PH_ACCEPTED : sdple_pkg::PH_ERROR;
			end
			sdple_pkg::PH_ACCEPTED: begin
				nph = sdple_pkg::PH_ACCEPTED;
			end
			default: begin
				nph = sdple_pkg::PH_ERROR;
			end
		endcase

		// Line break and end marker win over a delimiter that equals them.
		if (body) begin
			priority if (b == sdple_pkg::CH_CR) begin
				nie = 1'b0;
				nph = sdple_pkg::PH_AFTER_CR;
			end else if (b == sdple_pkg::CH_LF) begin
				nie = 1'b0;
				nph = sdple_pkg::PH_AFTER_LF;
			end else if (b == sdple_pkg::CH_NUL) begin
				nph = sdple_pkg::PH_ERROR;
			end else if (b == {1'b0, delim_q}) begin
				nie = 1'b0;
				nph = sdple_pkg::PH_BODY;
			end else begin
				if (!ie) begin
					start = 1'b1;
					if (cnt < sdple_pkg::CNT_LIMIT) begin
						ncnt = cnt + 1'b1;
					end
					nie = 1'b1;
				end
				role = sdple_pkg::ROLE_ELEMENT;
				nph = sdple_pkg::PH_BODY;
			end
		end

		if (nph == sdple_pkg::PH_ACCEPTED) begin
			status = sdple_pkg::ST_ACCEPTED;
		end else if (nph == sdple_pkg::PH_ERROR) begin
			status = sdple_pkg::ST_ERROR;
		end else begin
			status = sdple_pkg::ST_BUSY;
		end

		result.byte_out      = b;
		result.byte_role     = role;
		result.element_start = start;
		result.element_index = (role == sdple_pkg::ROLE_HEADER) ? '0 : ncnt;
		result.line_status   = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= sdple_pkg::DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sdple_pkg::PH_HEADER;
			in_elem_q <= 1'b0;
			count_q   <= '0;
		end else if (advance) begin
			phase_q   <= nph;
			in_elem_q <= nie;
			count_q   <= ncnt;
		end
	end

endmodule

>>> design/sdp_line_element_splitter.sv
// Splits a session-description line into a header and delimiter-separated
// elements, one byte per request, and echoes every byte with its role, an
// element-start flag, the element index and the line status. Assert the
// input tuser bit on the first byte of each line; the line must end in LF
// (optionally CR LF) followed by a zero byte. The block takes one byte
// every clock cycle while the output is not stalled; each byte is captured
// in the input register and parsed into the output register, from which its
// result is offered. A stalled output holds its result, and the input stops
// once both registers are full. The delimiter register (space after reset)
// must only be written while the block is idle.
module sdp_line_element_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] line_byte
	input  logic        s_tuser,   // [0] line_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] byte_out, [8] element_start,
	                               // [14:9] element_index, [16:15] line_status
	output logic [1:0]  m_tuser    // [1:0] byte_role
);

	sdple_pkg::item_t   item_s1;
	logic               valid_s1;
	sdple_pkg::result_t res;
	sdple_pkg::result_t res_s2;
	logic               valid_s2;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.line_byte  <= s_tdata;
			item_s1.line_start <= s_tuser;
		end
	end

	sdple_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.advance  (advance),
		.item     (item_s1),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.line_status, res_s2.element_index,
		res_s2.element_start, res_s2.byte_out};
	assign m_tuser  = res_s2.byte_role;

endmodule
